// ----- src/sfr_pkg.sv -----
`default_nettype none

package sfr_pkg;

  // width of the frame, ack and reject counters; they wrap at this width
  localparam int COUNTER_WIDTH = 32;
  // width of the counter fields on the result channel
  localparam int TOTAL_W       = 32;

  localparam int BYTE_W        = 8;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 8;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FLAG         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CTRL_SEQ0    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CTRL_SEQ1    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STUFFED_FLAG = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ESC_ESCAPE   = 3'd6;

  // configuration reset values
  localparam logic [BYTE_W-1:0] RST_FLAG         = 8'd126;
  localparam logic [BYTE_W-1:0] RST_ADDRESS      = 8'd3;
  localparam logic [BYTE_W-1:0] RST_CTRL_SEQ0    = 8'd0;
  localparam logic [BYTE_W-1:0] RST_CTRL_SEQ1    = 8'd64;
  localparam logic [BYTE_W-1:0] RST_ESCAPE       = 8'd125;
  localparam logic [BYTE_W-1:0] RST_STUFFED_FLAG = 8'd94;
  localparam logic [BYTE_W-1:0] RST_ESC_ESCAPE   = 8'd93;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
  localparam logic [1:0] KIND_VERDICT    = 2'd1;
  localparam logic [1:0] KIND_BAD_ESCAPE = 2'd2;

  // reply codes
  localparam logic [1:0] RSP_RR0  = 2'd0;
  localparam logic [1:0] RSP_RR1  = 2'd1;
  localparam logic [1:0] RSP_REJ0 = 2'd2;
  localparam logic [1:0] RSP_REJ1 = 2'd3;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_ADDR = 6'b000010,
    PH_CTRL = 6'b000100,
    PH_HCS  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_ESC  = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    EV_DATA       = 2'd0,
    EV_CLOSE      = 2'd1,
    EV_BAD_ESCAPE = 2'd2
  } ev_code_t;

  typedef struct packed {
    ev_code_t          code;
    logic [BYTE_W-1:0] data;
    logic              seq;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } queue_port_t;

  typedef struct packed {
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] ctrl_seq0;
    logic [BYTE_W-1:0] ctrl_seq1;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] stuffed_flag;
    logic [BYTE_W-1:0] esc_escape;
  } config_t;

endpackage

`default_nettype wire

// ----- src/sfr_rx_if.sv -----
`default_nettype none

interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/sfr_res_if.sv -----
`default_nettype none

interface sfr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        deliver;
  logic [1:0]  response;
  logic [31:0] frames_total;
  logic [31:0] acks_total;
  logic [31:0] rejects_total;

  modport source (
    output valid, output kind, output payload_byte, output deliver, output response,
    output frames_total, output acks_total, output rejects_total, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input deliver, input response,
    input frames_total, input acks_total, input rejects_total, output ready
  );
endinterface

`default_nettype wire

// ----- src/sfr_front.sv -----
`default_nettype none

module sfr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  sfr_rx_if.sink                           rx,
  input  logic                             queue_full,
  output sfr_pkg::queue_port_t             push
);
  import sfr_pkg::*;

  config_t cfg;
  phase_t  phase;
  phase_t  phase_next;
  logic    seq;
  logic    seq_next;
  logic    accept;
  logic [BYTE_W-1:0] c;

  assign rx.ready = !queue_full;
  assign accept   = rx.valid && rx.ready;
  assign c        = rx.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag         <= RST_FLAG;
      cfg.address      <= RST_ADDRESS;
      cfg.ctrl_seq0    <= RST_CTRL_SEQ0;
      cfg.ctrl_seq1    <= RST_CTRL_SEQ1;
      cfg.escape       <= RST_ESCAPE;
      cfg.stuffed_flag <= RST_STUFFED_FLAG;
      cfg.esc_escape   <= RST_ESC_ESCAPE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLAG:         cfg.flag         <= cfg_data;
        REG_ADDRESS:      cfg.address      <= cfg_data;
        REG_CTRL_SEQ0:    cfg.ctrl_seq0    <= cfg_data;
        REG_CTRL_SEQ1:    cfg.ctrl_seq1    <= cfg_data;
        REG_ESCAPE:       cfg.escape       <= cfg_data;
        REG_STUFFED_FLAG: cfg.stuffed_flag <= cfg_data;
        REG_ESC_ESCAPE:   cfg.esc_escape   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next    = phase;
    seq_next      = seq;
    push.valid    = 1'b0;
    push.ev.code  = EV_DATA;
    push.ev.data  = c;
    push.ev.seq   = seq;
    if (accept) begin
      case (phase)
        PH_ADDR: begin
          if (c == cfg.address)   phase_next = PH_CTRL;
          else if (c == cfg.flag) phase_next = PH_ADDR;
          else                    phase_next = PH_HUNT;
        end
        PH_CTRL: begin
          // equal control registers resolve to sequence 0
          if (c == cfg.ctrl_seq0) begin
            seq_next   = 1'b0;
            phase_next = PH_HCS;
          end else if (c == cfg.ctrl_seq1) begin
            seq_next   = 1'b1;
            phase_next = PH_HCS;
          end else if (c == cfg.flag) begin
            phase_next = PH_ADDR;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_HCS: begin
          if (c == (cfg.address ^ (seq ? cfg.ctrl_seq1 : cfg.ctrl_seq0)))
            phase_next = PH_DATA;
          else
            phase_next = PH_HUNT;
        end
        PH_DATA: begin
          if (c == cfg.flag) begin
            push.valid   = 1'b1;
            push.ev.code = EV_CLOSE;
            phase_next   = PH_HUNT;
          end else if (c == cfg.escape) begin
            phase_next   = PH_ESC;
          end else begin
            push.valid   = 1'b1;
          end
        end
        PH_ESC: begin
          push.valid = 1'b1;
          if (c == cfg.stuffed_flag) begin
            push.ev.data = cfg.flag;
            phase_next   = PH_DATA;
          end else if (c == cfg.esc_escape) begin
            push.ev.data = cfg.escape;
            phase_next   = PH_DATA;
          end else begin
            push.ev.code = EV_BAD_ESCAPE;
            phase_next   = PH_HUNT;
          end
        end
        default: begin
          phase_next = (c == cfg.flag) ? PH_ADDR : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      seq   <= 1'b0;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/sfr_queue.sv -----
`default_nettype none

module sfr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  sfr_pkg::queue_port_t push,
  input  logic                 pop,
  output sfr_pkg::queue_port_t head,
  output logic                 full
);
  import sfr_pkg::*;

  event_t                 entry [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.ev    = entry[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push.ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/sfr_back.sv -----
`default_nettype none

module sfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sfr_pkg::queue_port_t head,
  output logic                 pop,
  sfr_res_if.source            res
);
  import sfr_pkg::*;

  logic                     expected_seq;
  logic                     expected_seq_next;
  logic [BYTE_W-1:0]        run_xor;
  logic [BYTE_W-1:0]        run_xor_next;
  logic [BYTE_W-1:0]        held;
  logic [BYTE_W-1:0]        held_next;
  logic [1:0]               seen;
  logic [1:0]               seen_next;
  logic [COUNTER_WIDTH-1:0] frame_cnt;
  logic [COUNTER_WIDTH-1:0] frame_cnt_next;
  logic [COUNTER_WIDTH-1:0] ack_cnt;
  logic [COUNTER_WIDTH-1:0] ack_cnt_next;
  logic [COUNTER_WIDTH-1:0] rej_cnt;
  logic [COUNTER_WIDTH-1:0] rej_cnt_next;

  logic              out_valid;
  logic              out_valid_next;
  logic [1:0]        out_kind;
  logic [1:0]        out_kind_next;
  logic [BYTE_W-1:0] out_payload;
  logic [BYTE_W-1:0] out_payload_next;
  logic              out_deliver;
  logic              out_deliver_next;
  logic [1:0]        out_response;
  logic [1:0]        out_response_next;

  logic good;
  logic is_new;

  assign pop = head.valid && (!out_valid || res.ready);

  assign good   = (seen == 2'd2) && (run_xor == '0);
  assign is_new = (head.ev.seq == expected_seq);

  always_comb begin
    expected_seq_next = expected_seq;
    run_xor_next      = run_xor;
    held_next         = held;
    seen_next         = seen;
    frame_cnt_next    = frame_cnt;
    ack_cnt_next      = ack_cnt;
    rej_cnt_next      = rej_cnt;
    out_valid_next    = out_valid && !res.ready;
    out_kind_next     = out_kind;
    out_payload_next  = out_payload;
    out_deliver_next  = out_deliver;
    out_response_next = out_response;
    if (pop) begin
      out_valid_next    = 1'b0;
      out_payload_next  = '0;
      out_deliver_next  = 1'b0;
      out_response_next = RSP_RR0;
      case (head.ev.code)
        EV_DATA: begin
          // the held byte goes out only once a newer byte proves it is not the check
          out_valid_next   = (seen != 2'd0);
          out_kind_next    = KIND_PAYLOAD;
          out_payload_next = held;
          held_next        = head.ev.data;
          run_xor_next     = run_xor ^ head.ev.data;
          seen_next        = (seen == 2'd2) ? seen : seen + 2'd1;
        end
        EV_CLOSE: begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_VERDICT;
          if (good || !is_new) begin
            out_response_next = head.ev.seq ? RSP_RR0 : RSP_RR1;
            ack_cnt_next      = ack_cnt + 1'b1;
          end else begin
            out_response_next = head.ev.seq ? RSP_REJ1 : RSP_REJ0;
            rej_cnt_next      = rej_cnt + 1'b1;
          end
          if (good && is_new) begin
            out_deliver_next  = 1'b1;
            expected_seq_next = !expected_seq;
          end
          frame_cnt_next = frame_cnt + 1'b1;
          run_xor_next   = '0;
          held_next      = '0;
          seen_next      = 2'd0;
        end
        EV_BAD_ESCAPE: begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_BAD_ESCAPE;
          run_xor_next   = '0;
          held_next      = '0;
          seen_next      = 2'd0;
        end
        default: begin
          out_valid_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= 1'b0;
      run_xor      <= '0;
      held         <= '0;
      seen         <= 2'd0;
      frame_cnt    <= '0;
      ack_cnt      <= '0;
      rej_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      expected_seq <= expected_seq_next;
      run_xor      <= run_xor_next;
      held         <= held_next;
      seen         <= seen_next;
      frame_cnt    <= frame_cnt_next;
      ack_cnt      <= ack_cnt_next;
      rej_cnt      <= rej_cnt_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_kind     <= out_kind_next;
    out_payload  <= out_payload_next;
    out_deliver  <= out_deliver_next;
    out_response <= out_response_next;
  end

  // counters only move when a result is loaded, so they match the waiting beat
  assign res.valid         = out_valid;
  assign res.kind          = out_kind;
  assign res.payload_byte  = out_payload;
  assign res.deliver       = out_deliver;
  assign res.response      = out_response;
  assign res.frames_total  = TOTAL_W'(frame_cnt);
  assign res.acks_total    = TOTAL_W'(ack_cnt);
  assign res.rejects_total = TOTAL_W'(rej_cnt);

endmodule

`default_nettype wire

// ----- src/stuffed_frame_receiver.sv -----
`default_nettype none

// Byte-stuffed stop-and-wait frame receiver. One received byte is taken per clock on rx
// unless the queue is full; the front phase register classifies and destuffs it and a
// two-entry queue hands payload, closing-flag and bad-escape beats to the back end, which
// holds back the trailing check byte, judges the frame and keeps the wrapping frame, ack
// and reject counters. A result beat passes through the queue and then the output register
// on its way to res. rx.ready drops only when the queue is full, which can happen when res
// is stalled while bytes keep arriving. Configuration must be written through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce this.
// Indexes beyond the last register are ignored.
module stuffed_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  sfr_rx_if.sink                           rx,
  sfr_res_if.source                        res
);
  import sfr_pkg::*;

  queue_port_t push;
  queue_port_t head;
  logic        queue_full;
  logic        pop;

  sfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx         (rx),
    .queue_full (queue_full),
    .push       (push)
  );

  sfr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (queue_full)
  );

  sfr_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

endmodule

`default_nettype wire

// ----- src/sfr_checker.sv -----
`default_nettype none

module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic [1:0]  kind,
  input logic [7:0]  payload_byte,
  input logic        deliver,
  input logic [1:0]  response,
  input logic [31:0] frames_total,
  input logic [31:0] acks_total,
  input logic [31:0] rejects_total
);
  import sfr_pkg::*;

  logic [7:0] verdict_sum;
  assign verdict_sum = 8'(acks_total + rejects_total);

  // every closed frame picks exactly one reply
  a_counters_agree: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> verdict_sum == frames_total[7:0])
    else $error("frame count differs from ack plus reject count");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (kind == KIND_PAYLOAD || kind == KIND_VERDICT || kind == KIND_BAD_ESCAPE))
    else $error("unknown result kind");

  a_payload_only_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
    else $error("payload byte set on a non-data beat");

  // a delivered frame is always acked
  a_deliver_acks: assert property (@(posedge clk) disable iff (rst)
    res_valid && deliver |-> kind == KIND_VERDICT && (response == RSP_RR0 || response == RSP_RR1))
    else $error("delivery without an RR verdict");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat right after reset");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .kind          (res.kind),
  .payload_byte  (res.payload_byte),
  .deliver       (res.deliver),
  .response      (res.response),
  .frames_total  (res.frames_total),
  .acks_total    (res.acks_total),
  .rejects_total (res.rejects_total)
);

`default_nettype wire

// ----- verif/stuffed_frame_receiver_tb.sv -----
`default_nettype none

module stuffed_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_LIMIT   = 10;
  // index past the last register, the block must ignore it
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic [BYTE_W-1:0] byte_q_t [$];

  typedef struct packed {
    logic [1:0]         kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic               deliver;
    logic [1:0]         response;
    logic [TOTAL_W-1:0] frames_total;
    logic [TOTAL_W-1:0] acks_total;
    logic [TOTAL_W-1:0] rejects_total;
  } rx_result_t;

  typedef enum {
    FAULT_NONE,
    FAULT_CHECK,
    FAULT_ESCAPE,
    FAULT_HCS,
    FAULT_ADDR,
    FAULT_NO_CHECK,
    FAULT_NO_OPEN
  } frame_fault_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sfr_rx_if  rx_ch ();
  sfr_res_if res_ch ();

  stuffed_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  // receiver model state
  config_t                  cfg;
  phase_t                   link_phase;
  logic                     frame_seq;
  logic                     want_seq;
  logic [BYTE_W-1:0]        data_xor;
  logic [BYTE_W-1:0]        held_byte;
  logic [1:0]               data_seen;
  logic [COUNTER_WIDTH-1:0] frame_cnt;
  logic [COUNTER_WIDTH-1:0] ack_cnt;
  logic [COUNTER_WIDTH-1:0] rej_cnt;

  rx_result_t        expected_results [$];
  logic [BYTE_W-1:0] pending_bytes [$];

  int   bytes_queued;
  int   bytes_taken;
  int   mismatches;
  int   payload_beats;
  int   verdicts;
  int   deliveries;
  int   rejects;
  int   bad_escapes;
  int   settings_used;
  int   quiet_cycles;
  int   burst_left;
  int   gap_left;
  int   hold_req_cnt;
  int   hold_done_cnt;
  int   hold_left;
  int   pattern_left;
  logic [31:0] stall_pattern;
  logic next_seq;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic post_result(input logic [1:0] kind, input logic [BYTE_W-1:0] pay,
                             input logic dlv, input logic [1:0] resp);
    rx_result_t r;
    r.kind          = kind;
    r.payload_byte  = pay;
    r.deliver       = dlv;
    r.response      = resp;
    r.frames_total  = frame_cnt[TOTAL_W-1:0];
    r.acks_total    = ack_cnt[TOTAL_W-1:0];
    r.rejects_total = rej_cnt[TOTAL_W-1:0];
    expected_results.push_back(r);
  endtask

  // one destuffed byte; the byte held before it goes out as payload
  task automatic absorb_data(input logic [BYTE_W-1:0] d);
    if (data_seen >= 2'd1)
      post_result(KIND_PAYLOAD, held_byte, 1'b0, RSP_RR0);
    held_byte = d;
    data_xor  = data_xor ^ d;
    if (data_seen < 2'd2)
      data_seen = data_seen + 2'd1;
  endtask

  task automatic track_byte(input logic [BYTE_W-1:0] c);
    logic good;
    logic is_new;
    logic dlv;
    logic [1:0] resp;
    case (link_phase)
      PH_ADDR: begin
        if (c == cfg.address) link_phase = PH_CTRL;
        else if (c == cfg.flag) link_phase = PH_ADDR;
        else link_phase = PH_HUNT;
      end
      PH_CTRL: begin
        if (c == cfg.ctrl_seq0) begin
          frame_seq  = 1'b0;
          link_phase = PH_HCS;
        end else if (c == cfg.ctrl_seq1) begin
          frame_seq  = 1'b1;
          link_phase = PH_HCS;
        end else if (c == cfg.flag) begin
          link_phase = PH_ADDR;
        end else begin
          link_phase = PH_HUNT;
        end
      end
      PH_HCS: begin
        if (c == (cfg.address ^ (frame_seq ? cfg.ctrl_seq1 : cfg.ctrl_seq0))) begin
          link_phase = PH_DATA;
          data_xor   = '0;
          held_byte  = '0;
          data_seen  = '0;
        end else begin
          link_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (c == cfg.flag) begin
          good   = (data_seen >= 2'd2) && (data_xor == '0);
          is_new = (frame_seq == want_seq);
          dlv    = 1'b0;
          if (good || !is_new) begin
            resp    = frame_seq ? RSP_RR0 : RSP_RR1;
            ack_cnt = ack_cnt + 1'b1;
          end else begin
            resp    = frame_seq ? RSP_REJ1 : RSP_REJ0;
            rej_cnt = rej_cnt + 1'b1;
          end
          if (good && is_new) begin
            dlv      = 1'b1;
            want_seq = ~want_seq;
          end
          frame_cnt  = frame_cnt + 1'b1;
          link_phase = PH_HUNT;
          post_result(KIND_VERDICT, '0, dlv, resp);
        end else if (c == cfg.escape) begin
          link_phase = PH_ESC;
        end else begin
          absorb_data(c);
        end
      end
      PH_ESC: begin
        if (c == cfg.stuffed_flag) begin
          link_phase = PH_DATA;
          absorb_data(cfg.flag);
        end else if (c == cfg.esc_escape) begin
          link_phase = PH_DATA;
          absorb_data(cfg.escape);
        end else begin
          link_phase = PH_HUNT;
          post_result(KIND_BAD_ESCAPE, '0, 1'b0, RSP_RR0);
        end
      end
      default: link_phase = (c == cfg.flag) ? PH_ADDR : PH_HUNT;
    endcase
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic send_frame(input logic seq, input byte_q_t body, input frame_fault_t fault);
    logic [BYTE_W-1:0] ctl;
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] odd;
    byte_q_t raw;
    int bad_pos;
    ctl = seq ? cfg.ctrl_seq1 : cfg.ctrl_seq0;
    chk = '0;
    foreach (body[i]) chk = chk ^ body[i];
    if (fault != FAULT_NO_OPEN)
      push_byte(cfg.flag);
    if (fault == FAULT_ADDR) begin
      do odd = 8'($urandom); while (odd == cfg.address || odd == cfg.flag);
      push_byte(odd);
    end else begin
      push_byte(cfg.address);
    end
    push_byte(ctl);
    if (fault == FAULT_HCS)
      push_byte(cfg.address ^ ctl ^ 8'($urandom_range(1, 255)));
    else
      push_byte(cfg.address ^ ctl);
    raw = body;
    if (fault == FAULT_CHECK)
      raw.push_back(chk ^ 8'($urandom_range(1, 255)));
    else if (fault != FAULT_NO_CHECK)
      raw.push_back(chk);
    bad_pos = (raw.size() != 0) ? $urandom_range(0, raw.size() - 1) : 0;
    foreach (raw[i]) begin
      if (fault == FAULT_ESCAPE && i == bad_pos) begin
        do odd = 8'($urandom); while (odd == cfg.stuffed_flag || odd == cfg.esc_escape);
        push_byte(cfg.escape);
        push_byte(odd);
        return;
      end
      if (raw[i] == cfg.flag) begin
        push_byte(cfg.escape);
        push_byte(cfg.stuffed_flag);
      end else if (raw[i] == cfg.escape) begin
        push_byte(cfg.escape);
        push_byte(cfg.esc_escape);
      end else begin
        push_byte(raw[i]);
      end
    end
    push_byte(cfg.flag);
  endtask

  // sender stops, every result comes back, then the pipe settles
  task automatic drain();
    while (pending_bytes.size() != 0 || rx_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic program_config(input config_t c);
    write_reg(REG_FLAG, c.flag);
    write_reg(REG_ADDRESS, c.address);
    write_reg(REG_CTRL_SEQ0, c.ctrl_seq0);
    write_reg(REG_CTRL_SEQ1, c.ctrl_seq1);
    write_reg(REG_ESCAPE, c.escape);
    write_reg(REG_STUFFED_FLAG, c.stuffed_flag);
    write_reg(REG_ESC_ESCAPE, c.esc_escape);
    write_reg(REG_UNUSED, 8'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg    = c;
    settings_used++;
  endtask

  task automatic run_random(input int n);
    int start;
    int pick;
    int k;
    logic seq;
    byte_q_t body;
    frame_fault_t fault;
    start = bytes_queued;
    hold_req_cnt <= hold_req_cnt + 1;
    while (bytes_queued - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // line noise between frames
        k = $urandom_range(1, 4);
        repeat (k) push_byte(($urandom_range(0, 3) == 0) ? cfg.flag : 8'($urandom));
      end else begin
        if (pick < 70) fault = FAULT_NONE;
        else if (pick < 76) fault = FAULT_CHECK;
        else if (pick < 81) fault = FAULT_ESCAPE;
        else if (pick < 85) fault = FAULT_HCS;
        else if (pick < 89) fault = FAULT_ADDR;
        else if (pick < 93) fault = FAULT_NO_CHECK;
        else if (pick < 97) fault = FAULT_NO_OPEN;
        else begin
          fault = FAULT_NONE;
          push_byte(cfg.flag);
        end
        k = $urandom_range(0, 19);
        if (k == 0) k = 0;
        else if (k < 17) k = $urandom_range(1, 8);
        else k = $urandom_range(9, 32);
        body = {};
        repeat (k) begin
          if ($urandom_range(0, 5) == 0)
            body.push_back($urandom_range(0, 1) ? cfg.flag : cfg.escape);
          else
            body.push_back(8'($urandom));
        end
        seq = ($urandom_range(0, 6) == 0) ? ~next_seq : next_seq;
        send_frame(seq, body, fault);
        if (fault == FAULT_NONE && body.size() != 0 && seq == next_seq)
          next_seq = ~next_seq;
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= '0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        track_byte(rx_ch.rx_byte);
        bytes_taken++;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          rx_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= pending_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      pattern_left <= 0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_done_cnt != hold_req_cnt) begin
      hold_done_cnt <= hold_done_cnt + 1;
      hold_left     <= LONG_HOLD;
      res_ch.ready  <= 1'b0;
    end else if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern <= '1;
        1:       stall_pattern <= $urandom;
        2:       stall_pattern <= $urandom | $urandom;
        default: stall_pattern <= $urandom & $urandom;
      endcase
      pattern_left <= $urandom_range(20, 120);
      res_ch.ready <= 1'b1;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
      pattern_left  <= pattern_left - 1;
      res_ch.ready  <= stall_pattern[0];
    end
  end

  // result checker
  always @(posedge clk) begin
    rx_result_t want;
    rx_result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.kind          = res_ch.kind;
      got.payload_byte  = res_ch.payload_byte;
      got.deliver       = res_ch.deliver;
      got.response      = res_ch.response;
      got.frames_total  = res_ch.frames_total;
      got.acks_total    = res_ch.acks_total;
      got.rejects_total = res_ch.rejects_total;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result beat kind=%0d byte=%02h", $realtime, got.kind,
                   got.payload_byte);
      end else begin
        want = expected_results.pop_front();
        case (want.kind)
          KIND_PAYLOAD: payload_beats++;
          KIND_VERDICT: begin
            verdicts++;
            if (want.deliver) deliveries++;
            if (want.response == RSP_REJ0 || want.response == RSP_REJ1) rejects++;
          end
          default: bad_escapes++;
        endcase
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected kind=%0d byte=%02h dlv=%0b rsp=%0d frames=%0d acks=%0d rej=%0d",
                     want.kind, want.payload_byte, want.deliver, want.response,
                     want.frames_total, want.acks_total, want.rejects_total);
            $display("  actual   kind=%0d byte=%02h dlv=%0b rsp=%0d frames=%0d acks=%0d rej=%0d",
                     got.kind, got.payload_byte, got.deliver, got.response,
                     got.frames_total, got.acks_total, got.rejects_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    config_t c;
    byte_q_t body;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_FLAG;
    cfg_data      = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    cfg.flag         = RST_FLAG;
    cfg.address      = RST_ADDRESS;
    cfg.ctrl_seq0    = RST_CTRL_SEQ0;
    cfg.ctrl_seq1    = RST_CTRL_SEQ1;
    cfg.escape       = RST_ESCAPE;
    cfg.stuffed_flag = RST_STUFFED_FLAG;
    cfg.esc_escape   = RST_ESC_ESCAPE;
    link_phase    = PH_HUNT;
    frame_seq     = 1'b0;
    want_seq      = 1'b0;
    data_xor      = '0;
    held_byte     = '0;
    data_seen     = '0;
    frame_cnt     = '0;
    ack_cnt       = '0;
    rej_cnt       = '0;
    bytes_queued  = 0;
    bytes_taken   = 0;
    mismatches    = 0;
    payload_beats = 0;
    verdicts      = 0;
    deliveries    = 0;
    rejects       = 0;
    bad_escapes   = 0;
    settings_used = 1;
    quiet_cycles  = 0;
    burst_left    = 1;
    gap_left      = 0;
    hold_req_cnt  = 0;
    hold_done_cnt = 0;
    hold_left     = 0;
    pattern_left  = 0;
    stall_pattern = '1;
    next_seq      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: doubled opening flag with stuffed flag and escape in the payload,
    // an empty frame, then a bad escape
    push_byte(cfg.flag);
    body = {8'h7E, 8'h7D, 8'hFF};
    send_frame(1'b0, body, FAULT_NONE);
    body = {};
    send_frame(1'b1, body, FAULT_NO_CHECK);
    body = {8'h00};
    send_frame(1'b1, body, FAULT_ESCAPE);
    next_seq = 1'b1;
    drain();

    run_random(200);
    drain();

    // all-zero and all-one extremes
    c.flag         = 8'h00;
    c.address      = 8'hFF;
    c.ctrl_seq0    = 8'h00;
    c.ctrl_seq1    = 8'hFF;
    c.escape       = 8'hFF;
    c.stuffed_flag = 8'h00;
    c.esc_escape   = 8'hFF;
    program_config(c);
    run_random(150);
    drain();

    // both control bytes the same, so every frame reads as sequence zero
    c.flag         = 8'hFF;
    c.address      = 8'h00;
    c.ctrl_seq0    = 8'h5A;
    c.ctrl_seq1    = 8'h5A;
    c.escape       = 8'h00;
    c.stuffed_flag = 8'hFF;
    c.esc_escape   = 8'h01;
    program_config(c);
    run_random(150);
    drain();

    repeat (4) begin
      c.flag = 8'($urandom);
      do c.escape = 8'($urandom); while (c.escape == c.flag);
      c.address      = 8'($urandom);
      c.ctrl_seq0    = 8'($urandom);
      c.ctrl_seq1    = ($urandom_range(0, 7) == 0) ? c.ctrl_seq0 : 8'($urandom);
      c.stuffed_flag = 8'($urandom);
      do c.esc_escape = 8'($urandom); while (c.esc_escape == c.stuffed_flag);
      program_config(c);
      run_random(275);
      drain();
    end

    $display("run: %0d bytes in over %0d settings, %0d payload beats, %0d bad escapes",
             bytes_taken, settings_used, payload_beats, bad_escapes);
    $display("frames: %0d verdicts, %0d delivered, %0d rejected", verdicts, deliveries, rejects);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/sfr_pkg.sv
src/sfr_rx_if.sv
src/sfr_res_if.sv
src/sfr_front.sv
src/sfr_queue.sv
src/sfr_back.sv
src/stuffed_frame_receiver.sv
src/sfr_checker.sv
verif/stuffed_frame_receiver_tb.sv
